// ===== rtl/sha1bc_pkg.sv =====
// Shared types, constants and round helpers for the SHA-1 block compressor.
package sha1bc_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned DIGEST_WORDS = 5;

  localparam int unsigned POS_W   = $clog2(BLOCK_WORDS);
  localparam int unsigned ROUND_W = $clog2(ROUNDS);
  localparam int unsigned EMIT_W  = $clog2(DIGEST_WORDS);

  localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(BLOCK_WORDS - 1);
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
  localparam logic [EMIT_W-1:0]  LAST_EMIT  = EMIT_W'(DIGEST_WORDS - 1);

  // Standard initial chaining value, H0 first.
  localparam logic [WORD_W-1:0] IV [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round group: one per block of twenty rounds.
  typedef enum logic [1:0] {
    STAGE_CH  = 2'd0,
    STAGE_PAR = 2'd1,
    STAGE_MAJ = 2'd2,
    STAGE_PAR2 = 2'd3
  } stage_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ROUND = 2'd1,
    ST_ADD   = 2'd2,
    ST_EMIT  = 2'd3
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load_word;
    logic              reload_iv;
    logic              init_work;
    logic              do_round;
    stage_t            stage;
    logic              add_chain;
    logic [EMIT_W-1:0] emit_sel;
  } dp_cmd_t;

  function automatic logic [WORD_W-1:0] round_k(input stage_t s);
    case (s)
      STAGE_CH:  round_k = 32'h5A827999;
      STAGE_PAR: round_k = 32'h6ED9EBA1;
      STAGE_MAJ: round_k = 32'h8F1BBCDC;
      default:   round_k = 32'hCA62C1D6;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] mix_f(input stage_t s, input logic [WORD_W-1:0] b,
                                              input logic [WORD_W-1:0] c,
                                              input logic [WORD_W-1:0] d);
    case (s)
      STAGE_CH:  mix_f = (b & c) | (~b & d);
      STAGE_MAJ: mix_f = (b & c) | (b & d) | (c & d);
      default:   mix_f = b ^ c ^ d;
    endcase
  endfunction

endpackage

// ===== rtl/sha1bc_ctrl.sv =====
// Controller state machine: word counting, round sequencing and digest output.
module sha1bc_ctrl
  import sha1bc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    first_word,
  input  logic    last_word,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    digest_last,
  output dp_cmd_t cmd
);

  state_t             state, state_next;
  logic [POS_W-1:0]   pos;
  logic [ROUND_W-1:0] round;
  logic [EMIT_W-1:0]  emit;
  logic               pend_last;

  logic accept;
  logic full;
  logic out_xfer;

  assign accept   = in_valid && (state == ST_IDLE);
  assign full     = !first_word && (pos == LAST_POS);
  assign out_xfer = out_valid && out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && full) begin
          state_next = ST_ROUND;
        end else if (accept && last_word) begin
          state_next = ST_EMIT;
        end
      end
      ST_ROUND: begin
        if (round == LAST_ROUND) state_next = ST_ADD;
      end
      ST_ADD: begin
        state_next = pend_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_ready && (emit == LAST_EMIT)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready      = (state == ST_IDLE);
    out_valid     = (state == ST_EMIT);
    digest_last   = (emit == LAST_EMIT);
    cmd.load_word = accept;
    cmd.reload_iv = accept && first_word;
    cmd.init_work = accept && full;
    cmd.do_round  = (state == ST_ROUND);
    cmd.add_chain = (state == ST_ADD);
    cmd.emit_sel  = emit;
    if (round < ROUND_W'(20)) begin
      cmd.stage = STAGE_CH;
    end else if (round < ROUND_W'(40)) begin
      cmd.stage = STAGE_PAR;
    end else if (round < ROUND_W'(60)) begin
      cmd.stage = STAGE_MAJ;
    end else begin
      cmd.stage = STAGE_PAR2;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      round     <= '0;
      emit      <= '0;
      pend_last <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pend_last <= last_word;
        if (full || last_word) begin
          pos <= '0;
        end else if (first_word) begin
          pos <= POS_W'(1);
        end else begin
          pos <= pos + POS_W'(1);
        end
      end
      if (state == ST_ROUND) begin
        round <= (round == LAST_ROUND) ? '0 : round + ROUND_W'(1);
      end
      if (out_xfer) begin
        emit <= (emit == LAST_EMIT) ? '0 : emit + EMIT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/sha1bc_datapath.sv =====
// Datapath: schedule shift line, working registers and chaining value.
module sha1bc_datapath
  import sha1bc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  input  logic [WORD_W-1:0] message_word,
  output logic [WORD_W-1:0] digest_word
);

  logic [WORD_W-1:0] win  [BLOCK_WORDS];
  logic [WORD_W-1:0] work [DIGEST_WORDS];
  logic [WORD_W-1:0] hv   [DIGEST_WORDS];

  logic [WORD_W-1:0] w_mix;
  logic [WORD_W-1:0] w_new;
  logic [WORD_W-1:0] t_sum;

  // Schedule expansion from fixed taps of the window; win[0] is this round's word.
  always_comb begin
    w_mix = win[13] ^ win[8] ^ win[2] ^ win[0];
    w_new = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};
    t_sum = {work[0][WORD_W-6:0], work[0][WORD_W-1:WORD_W-5]}
          + mix_f(cmd.stage, work[1], work[2], work[3])
          + work[4] + win[0] + round_k(cmd.stage);
  end

  // Message window: words shift in during loading, expanded words during rounds.
  always_ff @(posedge clk) begin
    if (cmd.load_word || cmd.do_round) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[BLOCK_WORDS-1] <= cmd.load_word ? message_word : w_new;
    end
  end

  // Working registers a..e.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGEST_WORDS; i++) work[i] <= '0;
    end else if (cmd.init_work) begin
      for (int i = 0; i < DIGEST_WORDS; i++) work[i] <= hv[i];
    end else if (cmd.do_round) begin
      work[0] <= t_sum;
      work[1] <= work[0];
      work[2] <= {work[1][1:0], work[1][WORD_W-1:2]};
      work[3] <= work[2];
      work[4] <= work[3];
    end
  end

  // Chaining value.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGEST_WORDS; i++) hv[i] <= IV[i];
    end else if (cmd.reload_iv) begin
      for (int i = 0; i < DIGEST_WORDS; i++) hv[i] <= IV[i];
    end else if (cmd.add_chain) begin
      for (int i = 0; i < DIGEST_WORDS; i++) hv[i] <= hv[i] + work[i];
    end
  end

  assign digest_word = hv[cmd.emit_sel];

endmodule

// ===== rtl/sha1_block_compressor.sv =====
// Top level of the SHA-1 block compressor: controller plus datapath.
// Words are taken one per cycle while idle; the sixteenth word of a block starts
// the rounds and then the chain addition, and no word is taken until they finish.
// A last word is followed by five digest transfers, H0 to H4, one per cycle at most.
// Synchronous reset loads the initial chaining value and returns to word zero.
module sha1_block_compressor
  import sha1bc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] message_word,
  input  logic              first_word,
  input  logic              last_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] digest_word,
  output logic              digest_last
);

  dp_cmd_t cmd;

  sha1bc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .first_word  (first_word),
    .last_word   (last_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_last (digest_last),
    .cmd         (cmd)
  );

  sha1bc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .message_word (message_word),
    .digest_word  (digest_word)
  );

`ifndef ASSERT_OFF
  // Input is never taken while a digest is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while digest is pending");

  // The final digest transfer ends the output run.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && digest_last) |=> !out_valid)
    else $error("output continued after final digest word");

  // Rounds never run while words are being loaded.
  a_round_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.do_round |-> !in_ready)
    else $error("input ready during compression rounds");
`endif

endmodule
